// ===== sv/ued_pkg.sv =====
package ued_pkg;

	// Request field widths and stream packing
	localparam int OPCODE_W   = 3;
	localparam int KEY_IN_W   = 32;
	localparam int POSITION_W = 5;
	localparam int STATUS_W   = 3;
	localparam int DATA_OUT_W = 32;
	localparam int COUNT_W    = 5;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;

	// Request opcodes
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_ERASE      = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_READ       = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd7;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd4;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic eval;  // capture compare and read-select results
		logic ins;   // open a slot at the target and load the new key
		logic ers;   // close the slot at the target
	} cell_ctl_t;

endpackage

// ===== sv/ued_cell.sv =====
module ued_cell
	import ued_pkg::*;
#(
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 5,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic [KEY_WIDTH-1:0] req_key,
	input  logic [CNT_W-1:0]     target,
	input  logic [CNT_W-1:0]     count,
	input  logic [KEY_WIDTH-1:0] prev_key,   // key of the cell toward the front
	input  logic [KEY_WIDTH-1:0] next_key,   // key of the cell toward the back
	output logic [KEY_WIDTH-1:0] key_q,
	output logic                 hit_s1,
	output logic [KEY_WIDTH-1:0] rd_s1
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic occupied;
	logic at_target;
	logic past_target;

	assign occupied    = MY_IDX < count;
	assign at_target   = MY_IDX == target;
	assign past_target = MY_IDX > target;

	// Compare and read-select, registered for the commit cycle
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			hit_s1 <= occupied && (key_q == req_key);
			rd_s1  <= (occupied && at_target) ? key_q : '0;
		end
	end

	// Shift toward the back on insert, toward the front on erase
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_target) begin
				key_q <= req_key;
			end else if (past_target) begin
				key_q <= prev_key;
			end
		end else if (ctl.ers) begin
			if (at_target || past_target) begin
				key_q <= next_key;
			end
		end
	end

endmodule

// ===== sv/unique_entry_deque_top.sv =====
// Ordered double-ended queue of up to DEPTH keys that never stores a key twice.
// Requests (push back/front, pop front/back, insert, erase and read at a
// position from the front, clear) arrive on the s_ stream; each yields exactly
// one result on the m_ stream with a status, the key removed or read (zero
// otherwise) and the entry count afterwards. Keys live in a row of cells, one
// per entry, that all compare against the request key at once and shift one
// place toward the back on insert or toward the front on erase. A request is
// accepted, compared in every cell, then reduced and committed; requests are
// handled one at a time, and the next one is taken as soon as the previous has
// committed, even while its result still waits in the output register. Commit
// stalls only while that output register is still occupied and not being
// drained.
module unique_entry_deque_top
	import ued_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // opcode[2:0], key_value[34:3], position[39:35]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status[2:0], data_out[34:3], entry_count[39:35]
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

	typedef enum logic [1:0] {
		IDLE,
		EVAL,
		COMMIT
	} state_t;

	state_t                  state_q;
	logic [OPCODE_W-1:0]     op_q;
	logic [KEY_WIDTH-1:0]    key_q;
	logic [POSITION_W-1:0]   pos_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [M_TDATA_W-1:0]    out_data_q;

	logic [KEY_WIDTH-1:0]    cell_key [DEPTH];
	logic [KEY_WIDTH-1:0]    cell_rd  [DEPTH];
	logic [DEPTH-1:0]        cell_hit;

	cell_ctl_t               ctl;
	logic                    go;
	logic                    dup;
	logic                    full;
	logic [KEY_WIDTH-1:0]    rd_key;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        count_ext;
	logic [CNT_W-1:0]        target;
	logic [STATUS_W-1:0]     status;
	logic                    take_data;
	logic [CNT_W-1:0]        count_nxt;

	assign s_tready  = state_q == IDLE;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign pos_ext   = CMP_W'(pos_q);
	assign count_ext = CMP_W'(count_q);
	assign full      = count_q == CNT_W'(DEPTH);
	assign go        = (state_q == COMMIT) && (!out_valid_q || m_tready);

	// Slot that the request works on
	always_comb begin
		unique case (op_q) inside
			OP_PUSH_BACK: target = count_q;
			OP_PUSH_FRONT, OP_POP_FRONT: target = '0;
			OP_POP_BACK: target = count_q - CNT_W'(1);
			default: target = CNT_W'(pos_ext);
		endcase
	end

	// Reduce the cell results
	always_comb begin
		dup    = |cell_hit;
		rd_key = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_key = rd_key | cell_rd[i];
		end
	end

	// Decide status and shift for the request in commit
	always_comb begin
		status    = ST_OK;
		take_data = 1'b0;
		ctl.eval  = state_q == EVAL;
		ctl.ins   = 1'b0;
		ctl.ers   = 1'b0;
		count_nxt = count_q;
		unique case (op_q) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (dup) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins   = go;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					take_data = 1'b1;
					ctl.ers   = go;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (pos_ext > count_ext) begin
					status = ST_BADPOS;
				end else if (dup) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins   = go;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_ERASE: begin
				if (pos_ext >= count_ext) begin
					status = ST_BADPOS;
				end else begin
					take_data = 1'b1;
					ctl.ers   = go;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_ext >= count_ext) begin
					status = ST_BADPOS;
				end else begin
					take_data = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Sequencer, request registers, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			op_q        <= OP_PUSH_BACK;
			key_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Result register fills on commit, empties on an output transfer
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[OPCODE_W-1:0];
						key_q   <= KEY_WIDTH'(s_tdata[OPCODE_W +: KEY_IN_W]);
						pos_q   <= s_tdata[OPCODE_W+KEY_IN_W +: POSITION_W];
						state_q <= EVAL;
					end
				end
				EVAL: begin
					state_q <= COMMIT;
				end
				COMMIT: begin
					if (go) begin
						count_q     <= count_nxt;
						out_data_q  <= {COUNT_W'(count_nxt),
							take_data ? DATA_OUT_W'(rd_key) : DATA_OUT_W'(0), status};
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Row of key cells, front at cell 0
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_WIDTH-1:0] prev_key;
		logic [KEY_WIDTH-1:0] next_key;

		if (g == 0) begin : g_front
			assign prev_key = key_q;
		end else begin : g_mid_front
			assign prev_key = cell_key[g-1];
		end

		if (g == DEPTH - 1) begin : g_back
			assign next_key = cell_key[g];
		end else begin : g_mid_back
			assign next_key = cell_key[g+1];
		end

		ued_cell #(
			.KEY_WIDTH(KEY_WIDTH),
			.CNT_W    (CNT_W),
			.IDX      (g)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.req_key (key_q),
			.target  (target),
			.count   (count_q),
			.prev_key(prev_key),
			.next_key(next_key),
			.key_q   (cell_key[g]),
			.hit_s1  (cell_hit[g]),
			.rd_s1   (cell_rd[g])
		);
	end

endmodule

// ===== tb/unique_entry_deque_top_tb.sv =====
`timescale 1ns / 100ps

module unique_entry_deque_top_tb;
	import ued_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int CLK_PERIOD  = 10;
	localparam int DRAIN_WAIT  = 10;
	localparam int PHASE_ITEMS = 317;
	localparam int EXP_SLOTS   = 8;

	// Request and result layouts, last field in the low bits
	typedef struct packed {
		logic [POSITION_W-1:0] position;
		logic [KEY_IN_W-1:0]   key;
		logic [OPCODE_W-1:0]   opcode;
	} request_t;

	typedef struct packed {
		logic [COUNT_W-1:0]    count;
		logic [DATA_OUT_W-1:0] data;
		logic [STATUS_W-1:0]   status;
	} result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // opcode[2:0], key_value[34:3], position[39:35]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // status[2:0], data_out[34:3], entry_count[39:35]

	// Shadow of the deque contents, front at index 0
	logic [KEY_IN_W-1:0] shadow_keys [STORE_DEPTH];
	int                  shadow_count;
	// Expected results in transfer order, small ring with write and read indexes
	result_t             exp_ring [EXP_SLOTS];
	logic [2:0]          exp_wr;
	logic [2:0]          exp_rd;
	int                  err_count;
	int                  snd_idle_pct;
	int                  rcv_idle_pct;
	bit                  fill_mode;

	unique_entry_deque_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("unique_entry_deque_top_tb: done, errors");
		$finish;
	end

	function automatic bit results_pending();
		return exp_wr != exp_rd;
	endfunction

	// Deque predictor
	function automatic logic [STATUS_W-1:0] admit_status(logic [KEY_IN_W-1:0] key);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == key)
				return ST_DUP;
		end
		if (shadow_count >= STORE_DEPTH)
			return ST_FULL;
		return ST_OK;
	endfunction

	function automatic void place_key(int at, logic [KEY_IN_W-1:0] key);
		for (int i = shadow_count; i > at; i--)
			shadow_keys[i] = shadow_keys[i - 1];
		shadow_keys[at] = key;
		shadow_count++;
	endfunction

	function automatic logic [KEY_IN_W-1:0] remove_key(int at);
		logic [KEY_IN_W-1:0] key;
		key = shadow_keys[at];
		for (int i = at; i + 1 < shadow_count; i++)
			shadow_keys[i] = shadow_keys[i + 1];
		shadow_count--;
		return key;
	endfunction

	function automatic result_t apply_request(request_t req);
		result_t r;
		r.status = ST_OK;
		r.data   = '0;
		case (req.opcode) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				r.status = admit_status(req.key);
				if (r.status == ST_OK)
					place_key(req.opcode == OP_PUSH_BACK ? shadow_count : 0, req.key);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else
					r.data = remove_key(req.opcode == OP_POP_FRONT ? 0 : shadow_count - 1);
			end
			OP_INSERT: begin
				if (req.position > shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					r.status = admit_status(req.key);
					if (r.status == ST_OK)
						place_key(req.position, req.key);
				end
			end
			OP_ERASE: begin
				if (req.position >= shadow_count)
					r.status = ST_BADPOS;
				else
					r.data = remove_key(req.position);
			end
			OP_READ: begin
				if (req.position >= shadow_count)
					r.status = ST_BADPOS;
				else
					r.data = shadow_keys[req.position];
			end
			default: begin
				shadow_count = 0;
			end
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	// Send one request; idle gaps come before the transfer
	task automatic send_request(request_t req);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = req;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		exp_ring[exp_wr] = apply_request(req);
		exp_wr = exp_wr + 3'd1;
	endtask

	task automatic send_op(logic [OPCODE_W-1:0] op, logic [KEY_IN_W-1:0] key,
			logic [POSITION_W-1:0] pos);
		request_t req;
		req.opcode   = op;
		req.key      = key;
		req.position = pos;
		send_request(req);
	endtask

	// Hold the sender off until every outstanding result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (results_pending())
			@(posedge clk);
	endtask

	// Random request, mostly well formed; walks the count between empty and full
	function automatic request_t make_random_request();
		request_t req;
		int       c;
		int       k;
		if (shadow_count == STORE_DEPTH)
			fill_mode = 1'b0;
		else if (shadow_count == 0)
			fill_mode = 1'b1;

		// key: small pool for frequent duplicates, stored keys, or anything
		k = $urandom_range(0, 99);
		if (k < 50)
			req.key = $urandom_range(0, 23);
		else if (k < 68 && shadow_count > 0)
			req.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
		else
			req.key = $urandom;

		c = $urandom_range(0, 99);
		if (fill_mode) begin
			if (c < 1)       req.opcode = OP_CLEAR;
			else if (c < 22) req.opcode = OP_PUSH_BACK;
			else if (c < 40) req.opcode = OP_PUSH_FRONT;
			else if (c < 58) req.opcode = OP_INSERT;
			else if (c < 72) req.opcode = OP_READ;
			else if (c < 76) req.opcode = OP_POP_FRONT;
			else if (c < 80) req.opcode = OP_POP_BACK;
			else if (c < 90) req.opcode = OP_ERASE;
			else             req.opcode = OPCODE_W'($urandom_range(0, 7));
		end else begin
			if (c < 2)       req.opcode = OP_CLEAR;
			else if (c < 12) req.opcode = OP_PUSH_BACK;
			else if (c < 20) req.opcode = OP_PUSH_FRONT;
			else if (c < 28) req.opcode = OP_INSERT;
			else if (c < 42) req.opcode = OP_READ;
			else if (c < 60) req.opcode = OP_POP_FRONT;
			else if (c < 76) req.opcode = OP_POP_BACK;
			else if (c < 92) req.opcode = OP_ERASE;
			else             req.opcode = OPCODE_W'($urandom_range(0, 7));
		end

		// position: mostly within 0..count, sometimes anywhere in the field
		if ($urandom_range(0, 99) < 85)
			req.position = POSITION_W'($urandom_range(0, shadow_count));
		else
			req.position = POSITION_W'($urandom_range(0, 31));
		return req;
	endfunction

	// Refusals on an empty store
	task automatic test_empty_store();
		send_op(OP_POP_FRONT, 32'h0, 5'd0);
		send_op(OP_POP_BACK, 32'h0, 5'd0);
		send_op(OP_ERASE, 32'h0, 5'd0);
		send_op(OP_READ, 32'h0, 5'd0);
		send_op(OP_INSERT, 32'h1234_5678, 5'd1);
	endtask

	// Every operation but clear, key extremes, duplicate and position checks
	task automatic test_edges();
		send_op(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
		send_op(OP_PUSH_BACK, 32'h0000_0000, 5'd0);
		send_op(OP_PUSH_FRONT, 32'h8000_0000, 5'd0);
		send_op(OP_PUSH_BACK, 32'h0000_0000, 5'd0);    // duplicate
		send_op(OP_INSERT, 32'h7FFF_FFFF, 5'd3);       // position == count appends
		send_op(OP_INSERT, 32'h0000_0000, 5'd31);      // bad position wins over duplicate
		send_op(OP_READ, 32'h0, 5'd31);
		send_op(OP_READ, 32'h0, 5'd3);
		send_op(OP_ERASE, 32'h0, 5'd1);
		send_op(OP_POP_FRONT, 32'h0, 5'd0);
		send_op(OP_POP_BACK, 32'h0, 5'd0);
	endtask

	// Fill to capacity, then refuse, read and clear; duplicate is reported ahead of full
	task automatic test_full_store();
		for (int i = 0; i < STORE_DEPTH - 1; i++) begin
			case (i % 3)
				0: send_op(OP_PUSH_BACK, 32'h100 + i, 5'd0);
				1: send_op(OP_PUSH_FRONT, 32'h100 + i, 5'd0);
				default: send_op(OP_INSERT, 32'h100 + i, 5'($urandom_range(0, shadow_count)));
			endcase
		end
		send_op(OP_PUSH_BACK, 32'h0000_0000, 5'd0);
		send_op(OP_PUSH_FRONT, 32'hDEAD_0001, 5'd0);
		send_op(OP_INSERT, 32'hDEAD_0002, 5'd16);
		send_op(OP_INSERT, 32'hDEAD_0003, 5'd17);
		send_op(OP_ERASE, 32'h0, 5'd16);
		send_op(OP_READ, 32'h0, 5'd15);
		send_op(OP_CLEAR, 32'h0, 5'd0);
	endtask

	task automatic test_random(int n, int sidle, int ridle);
		snd_idle_pct = sidle;
		rcv_idle_pct = ridle;
		for (int i = 0; i < n; i++) begin
			send_request(make_random_request());
			if (i == n / 2)
				drain_results();
		end
		drain_results();
	endtask

	// Receiver ready, toggled at the falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (!results_pending()) begin
				$error("result transfer with nothing pending: %h", m_tdata);
				err_count++;
			end else begin
				want   = exp_ring[exp_rd];
				exp_rd = exp_rd + 3'd1;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					err_count++;
				end
				if (got.data !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, got.data);
					err_count++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, got.count);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		err_count    = 0;
		shadow_count = 0;
		exp_wr       = '0;
		exp_rd       = '0;
		fill_mode    = 1'b1;
		snd_idle_pct = 26;
		rcv_idle_pct = 68;
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_keys[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_store();
		test_edges();
		test_full_store();
		drain_results();
		test_random(PHASE_ITEMS, 26, 68);
		test_random(PHASE_ITEMS, 68, 26);
		test_random(PHASE_ITEMS, 0, 0);

		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && !results_pending())
			$display("unique_entry_deque_top_tb: done, clean");
		else
			$display("unique_entry_deque_top_tb: done, errors");
		$finish;
	end

endmodule

// ===== unique_entry_deque_top.f =====
sv/ued_pkg.sv
sv/ued_cell.sv
sv/unique_entry_deque_top.sv
tb/unique_entry_deque_top_tb.sv
